[sv/rsi_pkg.sv]
// ----------------------------------------------------------------------------
// rsi_pkg: shared constants, types and helpers for the ray/sphere intersector
// Fixed-point widths for every pipeline section and the structs that carry a
// ray and its side information between the pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  // Fraction bits of every fixed-point quantity.
  localparam int FRAC_BITS = 16;

  // Coordinate and radius widths.
  localparam int XW  = 32;
  localparam int RW  = 31;
  localparam int OCW = XW + 1;

  // Products and the quadratic coefficients.
  localparam int PW  = 2 * XW;
  localparam int A_W = PW - FRAC_BITS + 2;
  localparam int H_W = XW + OCW - FRAC_BITS + 2;
  localparam int C_W = A_W + 1;

  // Split multiplier operand width and half width.
  localparam int MW  = (H_W > C_W) ? H_W : C_W;
  localparam int MH  = (MW + 1) / 2;

  // Discriminant and its square root.
  localparam int DISC_W = 2 * MW + 1;
  localparam int ROOT_W = (DISC_W + 1) / 2;
  localparam int SQW    = 2 * ROOT_W;

  // Root numerators and the divider.
  localparam int MAG_W = ROOT_W + 1;
  localparam int NS_W  = MAG_W + 1;
  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int QW    = XW;
  localparam int REM_W = ((A_W + QW + 1) > NUM_W) ? (A_W + QW + 2) : (NUM_W + 1);

  // Hit point before saturation.
  localparam int PT_W = 2 * XW - FRAC_BITS + 2;

  // Stream payload widths.
  localparam int IN_W  = 8 * XW;
  localparam int OUT_W = 7 * XW;

  // Radius after reset: 1.5.
  localparam logic [RW-1:0] RADIUS_RST = RW'(3) << (FRAC_BITS - 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_CENTER_Z,
    CFG_RADIUS
  } cfg_idx_e;

  typedef logic signed [XW-1:0] coord_t;

  // One ray with its parameter window.
  typedef struct packed {
    coord_t [2:0] o;
    coord_t [2:0] d;
    coord_t       lo;
    coord_t       hi;
  } ray_t;

  // Side information that travels through the square root pipeline.
  typedef struct packed {
    ray_t                    ray;
    logic signed [H_W-1:0]   h;
    logic        [A_W-1:0]   a;
    logic                    isect;
  } sq_side_t;

  // Side information that travels through the divider pipeline.
  typedef struct packed {
    ray_t       ray;
    logic [1:0] neg;
    logic       isect;
    logic       az;
  } dv_side_t;

  // One finished result.
  typedef struct packed {
    logic         hit;
    coord_t       t;
    coord_t [2:0] pt;
    coord_t [2:0] nm;
  } res_t;

  // Saturate a wide signed value to a coordinate.
  function automatic coord_t sat_coord(input logic [PT_W-1:0] x);
    coord_t r;
    if (x[PT_W-1:XW-1] == {(PT_W - XW + 1){x[PT_W-1]}}) begin
      r = x[XW-1:0];
    end else begin
      r = {x[PT_W-1], {(XW - 1){~x[PT_W-1]}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/ray_sphere_intersect.sv]
// Throughput: one ray per cycle; the pipeline holds only while the two-entry
// output buffer is full. Depth is set by the 52-stage square root and the
// 33-stage divider.
// Reset: asynchronous, active low; clears all valid bits and the buffer, the
// sphere center to the origin and the radius to 1.5.
// ----------------------------------------------------------------------------
// ray_sphere_intersect: fixed-point ray against sphere test
// Solves the half-b quadratic, one ray per cycle while the buffer has room,
// picks the nearer root in the open window, gives hit point, unnormalized normal.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect import rsi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Ray stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_low, t_high
  input  logic [IN_W-1:0]  s_axis_tdata,
  // Result stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // t_value, point_x, point_y, point_z, normal_x, normal_y, normal_z
  output logic [OUT_W-1:0] m_axis_tdata,
  // hit
  output logic             m_axis_tuser,
  // Register writes.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [XW-1:0]    cfg_data_i
);

  logic en;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  coord_t        center_q [3];
  logic [RW-1:0] radius_q;
  cfg_idx_e      cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      radius_q    <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx)
        CFG_CENTER_X: center_q[0] <= cfg_data_i;
        CFG_CENTER_Y: center_q[1] <= cfg_data_i;
        CFG_CENTER_Z: center_q[2] <= cfg_data_i;
        CFG_RADIUS:   radius_q    <= cfg_data_i[RW-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack the ray and form origin minus center
  // --------------------------------------------------------------------------
  ray_t                  in_ray;
  logic signed [OCW-1:0] oc_d [3];
  logic                  s1_vld_q;
  ray_t                  s1_ray_q;
  logic signed [OCW-1:0] s1_oc_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_ray.o[i] = s_axis_tdata[i*XW +: XW];
      in_ray.d[i] = s_axis_tdata[(i+3)*XW +: XW];
      oc_d[i]     = $signed({in_ray.o[i][XW-1], in_ray.o[i]}) -
                    $signed({center_q[i][XW-1], center_q[i]});
    end
    in_ray.lo = s_axis_tdata[6*XW +: XW];
    in_ray.hi = s_axis_tdata[7*XW +: XW];
  end

  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ray_q <= in_ray;
      s1_oc_q  <= oc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: exact component products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0]       dd_d  [3];
  logic signed [XW+OCW-1:0]   doc_d [3];
  logic signed [2*OCW-1:0]    oo_d  [3];
  logic                       s2_vld_q;
  ray_t                       s2_ray_q;
  logic        [PW-1:0]       s2_dd_q  [3];
  logic signed [XW+OCW-1:0]   s2_doc_q [3];
  logic        [PW-1:0]       s2_oo_q  [3];
  logic        [2*RW-1:0]     s2_rr_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_d[i]  = $signed(s1_ray_q.d[i]) * $signed(s1_ray_q.d[i]);
      doc_d[i] = $signed(s1_ray_q.d[i]) * s1_oc_q[i];
      oo_d[i]  = s1_oc_q[i] * s1_oc_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ray_q <= s1_ray_q;
      for (int i = 0; i < 3; i++) begin
        s2_dd_q[i]  <= dd_d[i];
        s2_doc_q[i] <= doc_d[i];
        s2_oo_q[i]  <= oo_d[i][PW-1:0];
      end
      s2_rr_q <= radius_q * radius_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale and sum into A, H and C
  // --------------------------------------------------------------------------
  logic        [A_W-1:0] a_d, oq_d;
  logic signed [H_W-1:0] h_d;
  logic signed [C_W-1:0] cc_d;
  logic                  s3_vld_q;
  ray_t                  s3_ray_q;
  logic        [A_W-1:0] s3_a_q;
  logic signed [H_W-1:0] s3_h_q;
  logic signed [C_W-1:0] s3_cc_q;

  always_comb begin
    a_d  = '0;
    oq_d = '0;
    h_d  = '0;
    for (int i = 0; i < 3; i++) begin
      a_d  = a_d + A_W'(s2_dd_q[i][PW-1:FRAC_BITS]);
      oq_d = oq_d + A_W'(s2_oo_q[i][PW-1:FRAC_BITS]);
      h_d  = h_d + H_W'(s2_doc_q[i] >>> FRAC_BITS);
    end
    cc_d = $signed({1'b0, oq_d}) - $signed(C_W'(s2_rr_q[2*RW-1:FRAC_BITS]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ray_q <= s2_ray_q;
      s3_a_q   <= a_d;
      s3_h_q   <= h_d;
      s3_cc_q  <= cc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: H squared and A times |C| in split multipliers
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] hx, cx;
  logic        [MW-1:0] abs_h, abs_c;
  logic [2*MW-1:0]      hh, ac;
  logic                 w1_vld_q, w2_vld_q;
  ray_t                 w1_ray_q, w2_ray_q;
  logic        [A_W-1:0] w1_a_q, w2_a_q;
  logic signed [H_W-1:0] w1_h_q, w2_h_q;
  logic                 w1_cneg_q, w2_cneg_q;

  assign hx    = MW'(s3_h_q);
  assign cx    = MW'(s3_cc_q);
  assign abs_h = hx[MW-1] ? MW'(-hx) : MW'(hx);
  assign abs_c = cx[MW-1] ? MW'(-cx) : MW'(cx);

  rsi_wmul u_mul_hh (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (abs_h),
    .y_i   (abs_h),
    .p_o   (hh)
  );

  rsi_wmul u_mul_ac (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (MW'(s3_a_q)),
    .y_i   (abs_c),
    .p_o   (ac)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_vld_q <= 1'b0;
      w2_vld_q <= 1'b0;
    end else if (en) begin
      w1_vld_q <= s3_vld_q;
      w2_vld_q <= w1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_ray_q  <= s3_ray_q;
      w1_a_q    <= s3_a_q;
      w1_h_q    <= s3_h_q;
      w1_cneg_q <= s3_cc_q[C_W-1];
      w2_ray_q  <= w1_ray_q;
      w2_a_q    <= w1_a_q;
      w2_h_q    <= w1_h_q;
      w2_cneg_q <= w1_cneg_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: discriminant and intersection flag
  // --------------------------------------------------------------------------
  logic [DISC_W-1:0] disc_d;
  logic              isect_d;
  logic              s6_vld_q;
  logic [DISC_W-1:0] s6_disc_q;
  sq_side_t          s6_side_q;

  always_comb begin
    if (w2_cneg_q) begin
      disc_d  = DISC_W'(hh) + DISC_W'(ac);
      isect_d = disc_d != '0;
    end else begin
      disc_d  = DISC_W'(hh) - DISC_W'(ac);
      isect_d = hh > ac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= w2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_disc_q       <= disc_d;
      s6_side_q.ray   <= w2_ray_q;
      s6_side_q.h     <= w2_h_q;
      s6_side_q.a     <= w2_a_q;
      s6_side_q.isect <= isect_d;
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipeline
  // --------------------------------------------------------------------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  rsi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s6_vld_q),
    .disc_i (s6_disc_q),
    .side_i (s6_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // --------------------------------------------------------------------------
  // Numerator stage: -H - S and -H + S as sign and magnitude
  // --------------------------------------------------------------------------
  logic signed [NS_W-1:0] hn, sx;
  logic signed [NS_W-1:0] num_d [2];
  logic [1:0][MAG_W-1:0]  mag_d;
  logic [1:0]             neg_d;
  logic                   nm_vld_q;
  logic [1:0][MAG_W-1:0]  nm_mag_q;
  logic [A_W-1:0]         nm_a_q;
  dv_side_t               nm_side_q;

  assign hn = -$signed({{(NS_W - H_W){sq_side.h[H_W-1]}}, sq_side.h});
  assign sx = $signed({{(NS_W - ROOT_W){1'b0}}, sq_root});

  always_comb begin
    num_d[0] = hn - sx;
    num_d[1] = hn + sx;
    for (int l = 0; l < 2; l++) begin
      neg_d[l] = num_d[l][NS_W-1];
      mag_d[l] = neg_d[l] ? MAG_W'(-num_d[l]) : MAG_W'(num_d[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q <= 1'b0;
    end else if (en) begin
      nm_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_mag_q        <= mag_d;
      nm_a_q          <= sq_side.a;
      nm_side_q.ray   <= sq_side.ray;
      nm_side_q.neg   <= neg_d;
      nm_side_q.isect <= sq_side.isect;
      nm_side_q.az    <= sq_side.a == '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline
  // --------------------------------------------------------------------------
  logic               dv_vld;
  logic [1:0][QW-1:0] dv_quo;
  logic [1:0]         dv_ovf;
  dv_side_t           dv_side;

  rsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (nm_vld_q),
    .mag_i  (nm_mag_q),
    .a_i    (nm_a_q),
    .side_i (nm_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .ovf_o  (dv_ovf),
    .side_o (dv_side)
  );

  // --------------------------------------------------------------------------
  // Select stage: saturate both roots and test them against the window
  // --------------------------------------------------------------------------
  coord_t     tn [2];
  logic [1:0] win;
  logic       hit_d;
  coord_t     t_d;
  logic       sl_vld_q;
  logic       sl_hit_q;
  logic       sl_isect_q;
  coord_t     sl_t_q;
  ray_t       sl_ray_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv_side.neg[l]) begin
        if (dv_ovf[l] || (dv_quo[l][QW-1] && (|dv_quo[l][QW-2:0]))) begin
          tn[l] = {1'b1, {(XW - 1){1'b0}}};
        end else begin
          tn[l] = -dv_quo[l];
        end
      end else begin
        if (dv_ovf[l] || dv_quo[l][QW-1]) begin
          tn[l] = {1'b0, {(XW - 1){1'b1}}};
        end else begin
          tn[l] = dv_quo[l];
        end
      end
      win[l] = ($signed(dv_side.ray.lo) < $signed(tn[l])) &&
               ($signed(tn[l]) < $signed(dv_side.ray.hi));
    end
    hit_d = !dv_side.az && (|win);
    if (!hit_d) begin
      t_d = '0;
    end else if (win[0]) begin
      t_d = tn[0];
    end else begin
      t_d = tn[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_vld_q <= 1'b0;
    end else if (en) begin
      sl_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sl_hit_q   <= hit_d;
      sl_isect_q <= dv_side.isect;
      sl_t_q     <= t_d;
      sl_ray_q   <= dv_side.ray;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: t times each direction component
  // --------------------------------------------------------------------------
  logic                 mu_vld_q;
  logic                 mu_hit_q;
  logic                 mu_isect_q;
  coord_t               mu_t_q;
  coord_t               mu_o_q [3];
  logic signed [PW-1:0] mu_prod_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (en) begin
      mu_vld_q <= sl_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_hit_q   <= sl_hit_q;
      mu_isect_q <= sl_isect_q;
      mu_t_q     <= sl_t_q;
      for (int i = 0; i < 3; i++) begin
        mu_o_q[i]    <= sl_ray_q.o[i];
        mu_prod_q[i] <= $signed(sl_t_q) * $signed(sl_ray_q.d[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: hit point, normal and saturation into the output buffer
  // --------------------------------------------------------------------------
  logic signed [PT_W-1:0] pt [3];
  logic signed [PT_W-1:0] nv [3];
  res_t                   res_d;
  res_t                   res_q;

  always_comb begin
    res_d = '0;
    for (int i = 0; i < 3; i++) begin
      pt[i] = $signed({{(PT_W - XW){mu_o_q[i][XW-1]}}, mu_o_q[i]}) +
              $signed(PT_W'(mu_prod_q[i] >>> FRAC_BITS));
      nv[i] = pt[i] - $signed({{(PT_W - XW){center_q[i][XW-1]}}, center_q[i]});
    end
    if (mu_isect_q) begin
      res_d.hit = mu_hit_q;
      res_d.t   = mu_t_q;
      for (int i = 0; i < 3; i++) begin
        res_d.pt[i] = sat_coord(pt[i]);
        res_d.nm[i] = sat_coord(nv[i]);
      end
    end
  end

  rsi_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && mu_vld_q),
    .data_i  (res_d),
    .room_o  (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_q)
  );

  // Output packing.
  always_comb begin
    m_axis_tdata[XW-1:0] = res_q.t;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[(i+1)*XW +: XW] = res_q.pt[i];
      m_axis_tdata[(i+4)*XW +: XW] = res_q.nm[i];
    end
  end

  assign m_axis_tuser = res_q.hit;

endmodule

`default_nettype wire

[sv/rsi_wmul.sv]
// ----------------------------------------------------------------------------
// rsi_wmul: two-stage wide unsigned multiplier
// Splits both operands into halves, registers the four partial products and
// then registers their aligned sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_wmul import rsi_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [MW-1:0]   x_i,
  input  logic [MW-1:0]   y_i,
  output logic [2*MW-1:0] p_o
);

  localparam int PP_W = 4 * MH;

  logic [MH-1:0]     xl, xh, yl, yh;
  logic [2*MH-1:0]   pll_q, plh_q, phl_q, phh_q;
  logic [PP_W-1:0]   sum;
  logic [2*MW-1:0]   p_q;

  assign xl = x_i[MH-1:0];
  assign xh = MH'(x_i[MW-1:MH]);
  assign yl = y_i[MH-1:0];
  assign yh = MH'(y_i[MW-1:MH]);

  // First stage: four half-width partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= xl * yl;
      plh_q <= xl * yh;
      phl_q <= xh * yl;
      phh_q <= xh * yh;
    end
  end

  // Second stage: align and add the partial products.
  assign sum = ((PP_W)'(phh_q) << (2 * MH)) + ((PP_W)'(plh_q) << MH) +
               ((PP_W)'(phl_q) << MH) + (PP_W)'(pll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum[2*MW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[sv/rsi_sqrt.sv]
// ----------------------------------------------------------------------------
// rsi_sqrt: pipelined integer square root
// Produces the floor of the square root of the discriminant, one result bit
// per stage, with the ray side information carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt import rsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [DISC_W-1:0] disc_i,
  input  sq_side_t          side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output sq_side_t          side_o
);

  logic              vld_q  [ROOT_W];
  logic [SQW-1:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  sq_side_t          side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;

    logic              pv;
    logic [SQW-1:0]    prem;
    logic [ROOT_W-1:0] proot;
    sq_side_t          pside;
    logic [SQW-1:0]    trial;
    logic              ge;

    // Previous stage, or the pipeline input for the first one.
    if (k == 0) begin : g_first
      assign pv    = vld_i;
      assign prem  = SQW'(disc_i);
      assign proot = '0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = vld_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign pside = side_q[k-1];
    end

    // (R + 2^B)^2 - R^2 = R * 2^(B+1) + 2^(2B).
    assign trial = (SQW'(proot) << (B + 1)) | (SQW'(1) << (2 * B));
    assign ge    = prem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (prem - trial) : prem;
        root_q[k] <= ge ? (proot | (ROOT_W'(1) << B)) : proot;
        side_q[k] <= pside;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

`default_nettype wire

[sv/rsi_div.sv]
// ----------------------------------------------------------------------------
// rsi_div: pipelined two-lane restoring divider
// Divides both root numerators, scaled by the fraction, by the quadratic
// coefficient. The first stage flags quotients that exceed the result width;
// each following stage resolves one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div import rsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [1:0][MAG_W-1:0] mag_i,
  input  logic [A_W-1:0]        a_i,
  input  dv_side_t              side_i,
  output logic                  vld_o,
  output logic [1:0][QW-1:0]    quo_o,
  output logic [1:0]            ovf_o,
  output dv_side_t              side_o
);

  logic                  vld_q  [QW+1];
  logic [A_W-1:0]        a_q    [QW+1];
  dv_side_t              side_q [QW+1];
  logic [1:0][REM_W-1:0] rem_q  [QW+1];
  logic [1:0][QW-1:0]    quo_q  [QW+1];
  logic [1:0]            ovf_q  [QW+1];

  logic [1:0][REM_W-1:0] num0;
  logic [1:0]            ovf0;
  logic [REM_W-1:0]      lim0;

  // Entry stage: a quotient of 2^QW or more saturates anyway.
  assign lim0 = REM_W'(a_i) << QW;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      num0[l] = REM_W'({mag_i[l], {FRAC_BITS{1'b0}}});
      ovf0[l] = num0[l] >= lim0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]    <= a_i;
      side_q[0] <= side_i;
      rem_q[0]  <= num0;
      quo_q[0]  <= '0;
      ovf_q[0]  <= ovf0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;

    logic [REM_W-1:0]      sub;
    logic [1:0][REM_W-1:0] rem_d;
    logic [1:0][QW-1:0]    quo_d;

    assign sub = REM_W'(a_q[k-1]) << B;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (rem_q[k-1][l] >= sub) begin
          rem_d[l] = rem_q[k-1][l] - sub;
          quo_d[l] = quo_q[k-1][l] | (QW'(1) << B);
        end else begin
          rem_d[l] = rem_q[k-1][l];
          quo_d[l] = quo_q[k-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]    <= a_q[k-1];
        side_q[k] <= side_q[k-1];
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[QW];
  assign quo_o  = quo_q[QW];
  assign ovf_o  = ovf_q[QW];
  assign side_o = side_q[QW];

endmodule

`default_nettype wire

[sv/rsi_obuf.sv]
// ----------------------------------------------------------------------------
// rsi_obuf: two-entry output buffer
// Holds finished results for the master stream and tells the pipeline when
// it may advance.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_obuf import rsi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic room_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  localparam logic [1:0] FULL = 2'd2;

  res_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign room_o  = cnt_q != FULL;
  assign data_o  = mem_q[rp_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[sv/rsi_checker.sv]
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for the ray/sphere intersector
// Watches the streams of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_checker import rsi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  // A stalled result transaction keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // No result can appear right after reset.
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Input back-pressure only while results wait.
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // Taking a result from a full buffer frees the input.
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !s_axis_tready |=> s_axis_tready)
    else $error("input not released after a result transaction");

  // A miss reports a zero parameter.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[XW-1:0] == '0)
    else $error("nonzero t without a hit");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);

`default_nettype wire

[tb/ray_sphere_intersect_tb.sv]
// ----------------------------------------------------------------------------
// ray_sphere_intersect_tb: self-checking bench for the ray/sphere intersector
// Streams directed and random rays through the block under several sphere
// settings, predicts every result with an exact fixed-point solver and checks
// the result stream in order, field by field, under random flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_tb;
  import rsi_pkg::*;

  localparam int LATENCY = 95;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [XW-1:0]    cfg_data_i;

  // Expected result of one ray.
  typedef struct {
    logic            hit;
    logic [XW-1:0]   t;
    logic [XW-1:0]   pt [3];
    logic [XW-1:0]   nm [3];
  } hit_rec_t;

  hit_rec_t        hits_due [$];
  logic signed [XW-1:0] sph_center [3];
  logic [RW-1:0]   sph_radius;
  int              error_count;
  int              rays_sent;
  int              results_seen;
  int              send_idle_pct;
  int              recv_idle_pct;
  logic            hold_on;

  ray_sphere_intersect DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Floor division by 2^FRAC_BITS of a wide signed value.
  function automatic logic signed [255:0] floor_shift(input logic signed [255:0] x);
    return x >>> FRAC_BITS;
  endfunction

  // Integer square root, floor.
  function automatic logic [255:0] isqrt(input logic [255:0] v);
    logic [255:0] res;
    logic [255:0] c;
    res = 0;
    for (int b = 127; b >= 0; b--) begin
      c = res | (256'd1 << b);
      if (c * c <= v) res = c;
    end
    return res;
  endfunction

  // Root (num * 2^FRAC_BITS) / a truncated toward zero and saturated.
  function automatic logic signed [63:0] root_param(input logic signed [255:0] num,
                                                    input logic signed [255:0] a);
    logic signed [255:0] q;
    q = (num <<< FRAC_BITS) / a;
    if (q > 256'sd2147483647) return 64'sd2147483647;
    if (q < -256'sd2147483648) return -64'sd2147483648;
    return q[63:0];
  endfunction

  function automatic logic [XW-1:0] sat_word(input logic signed [255:0] x);
    if (x > 256'sd2147483647) return 32'h7fffffff;
    if (x < -256'sd2147483648) return 32'h80000000;
    return x[XW-1:0];
  endfunction

  // Exact intersection solve of one ray against the current sphere.
  function automatic hit_rec_t solve_ray(input ray_t r);
    hit_rec_t res;
    logic signed [255:0] o [3];
    logic signed [255:0] d [3];
    logic signed [255:0] oc [3];
    logic signed [255:0] a, h, cc, rr, disc, s, tn, t, lo, hi, p;
    a = 0; h = 0; cc = 0; t = 0;
    res.hit = 1'b0;
    res.t = '0;
    for (int i = 0; i < 3; i++) begin
      o[i] = r.o[i];
      d[i] = r.d[i];
      oc[i] = o[i] - 256'(signed'(sph_center[i]));
      a += floor_shift(d[i] * d[i]);
      h += floor_shift(d[i] * oc[i]);
      cc += floor_shift(oc[i] * oc[i]);
      res.pt[i] = '0;
      res.nm[i] = '0;
    end
    rr = $signed({225'd0, sph_radius});
    cc -= floor_shift(rr * rr);
    lo = r.lo;
    hi = r.hi;
    disc = h * h - a * cc;
    if (disc <= 0) return res;
    if (a != 0) begin
      s = isqrt(disc);
      tn = root_param(-h - s, a);
      if (lo < tn && tn < hi) begin
        res.hit = 1'b1;
        t = tn;
      end else begin
        tn = root_param(-h + s, a);
        if (lo < tn && tn < hi) begin
          res.hit = 1'b1;
          t = tn;
        end
      end
    end
    res.t = t[XW-1:0];
    for (int i = 0; i < 3; i++) begin
      p = o[i] + floor_shift(t * d[i]);
      res.pt[i] = sat_word(p);
      res.nm[i] = sat_word(p - 256'(signed'(sph_center[i])));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [XW-1:0] got,
                                 input logic [XW-1:0] want);
    $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
    error_count++;
  endtask

  // Result checker and receiver flow control.
  always @(posedge clk_i or negedge rst_ni) begin
    hit_rec_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_due.size() == 0) begin
          report_mismatch("transaction with no ray outstanding, t_value",
                          m_axis_tdata[XW-1:0], '0);
        end else begin
          w = hits_due.pop_front();
          if (m_axis_tuser !== w.hit) report_mismatch("hit", XW'(m_axis_tuser), XW'(w.hit));
          if (m_axis_tdata[XW-1:0] !== w.t) begin
            report_mismatch("t_value", m_axis_tdata[XW-1:0], w.t);
          end
          for (int i = 0; i < 3; i++) begin
            if (m_axis_tdata[(i+1)*XW +: XW] !== w.pt[i]) begin
              report_mismatch("point", m_axis_tdata[(i+1)*XW +: XW], w.pt[i]);
            end
            if (m_axis_tdata[(i+4)*XW +: XW] !== w.nm[i]) begin
              report_mismatch("normal", m_axis_tdata[(i+4)*XW +: XW], w.nm[i]);
            end
          end
        end
        results_seen++;
      end
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Send one ray; its expectation is queued when the transaction completes.
  task automatic send_ray(input ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.hi, r.lo, r.d[2], r.d[1], r.d[0], r.o[2], r.o[1], r.o[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    hits_due.insert(hits_due.size(), solve_ray(r));
    rays_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [XW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CENTER_X: sph_center[0] = value;
      CFG_CENTER_Y: sph_center[1] = value;
      CFG_CENTER_Z: sph_center[2] = value;
      default:      sph_radius = value[RW-1:0];
    endcase
  endtask

  task automatic set_sphere(input logic [XW-1:0] cx, input logic [XW-1:0] cy,
                            input logic [XW-1:0] cz, input logic [XW-1:0] rad);
    drain();
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [XW-1:0] any_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS);
    endcase
  endfunction

  // A ray aimed roughly at the current sphere with random window.
  function automatic ray_t aimed_ray();
    ray_t r;
    int sc;
    sc = $urandom_range(4) << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = sph_center[i] + $signed($urandom_range(2 * sc)) - sc;
      r.d[i] = $signed($urandom_range(4 << FRAC_BITS)) - (2 << FRAC_BITS);
    end
    // Point the ray back toward the center now and then.
    if ($urandom_range(1)) begin
      for (int i = 0; i < 3; i++) r.d[i] = (sph_center[i] - r.o[i]) >>> $urandom_range(3);
    end
    r.lo = ($urandom_range(3) == 0) ? any_word() : -$signed($urandom_range(1 << FRAC_BITS));
    r.hi = ($urandom_range(3) == 0) ? any_word() : $signed($urandom_range(20 << FRAC_BITS));
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.o[i] = any_word();
      r.d[i] = any_word();
    end
    r.lo = any_word();
    r.hi = any_word();
    return r;
  endfunction

  // Extremes of every field, zero direction, empty windows, misses and hits.
  task automatic test_directed;
    ray_t r;
    logic [XW-1:0] ext [4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        r.o[i] = ext[k];
        r.d[i] = ext[(k + 1) % 4];
      end
      r.lo = 32'h80000000;
      r.hi = 32'h7fffffff;
      send_ray(r);
      r.lo = ext[k];
      r.hi = ext[(k + 2) % 4];
      send_ray(r);
    end
    // Head-on ray from x = -4 along +x: hit at t = 2.5.
    r.o = '{-(4 << FRAC_BITS), 0, 0};
    r.d = '{1 << FRAC_BITS, 0, 0};
    r.lo = 0;
    r.hi = 100 << FRAC_BITS;
    send_ray(r);
    // Same ray, window admits only the farther root.
    r.lo = 3 << FRAC_BITS;
    send_ray(r);
    // Window excludes both roots, then an inverted window.
    r.lo = 10 << FRAC_BITS;
    send_ray(r);
    r.lo = 5 << FRAC_BITS;
    r.hi = 1 << FRAC_BITS;
    send_ray(r);
    // Zero direction from inside the sphere.
    r.o = '{0, 0, 0};
    r.d = '{0, 0, 0};
    r.lo = 32'h80000000;
    r.hi = 32'h7fffffff;
    send_ray(r);
    // Clean miss and a tangent ray.
    r.o = '{-(4 << FRAC_BITS), 5 << FRAC_BITS, 0};
    r.d = '{1 << FRAC_BITS, 0, 0};
    send_ray(r);
    r.o = '{-(4 << FRAC_BITS), 3 << (FRAC_BITS - 1), 0};
    send_ray(r);
    // Origin inside the sphere: near root negative, far root wins.
    r.o = '{0, 0, 0};
    r.lo = 0;
    send_ray(r);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 8) send_ray(aimed_ray());
      else send_ray(noise_ray());
    end
  endtask

  // Receiver holds off long enough for the pipeline and buffer to fill.
  task automatic test_backpressure;
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    for (int n = 0; n < 150; n++) send_ray(aimed_ray());
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CENTER_X;
    cfg_data_i = '0;
    error_count = 0;
    rays_sent = 0;
    results_seen = 0;
    hold_on = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    sph_center = '{0, 0, 0};
    sph_radius = RADIUS_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500);
    set_sphere(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff);
    test_random(150);
    set_sphere(3 << FRAC_BITS, -(2 << FRAC_BITS), 1 << FRAC_BITS, 0);
    test_random(150);
    send_idle_pct = 68;
    recv_idle_pct = 19;
    set_sphere(-(10 << FRAC_BITS), 7 << FRAC_BITS, 32'hfff00000, 5 << FRAC_BITS);
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    set_sphere(32'h80000000, 32'h7fffffff, 32'hffffffff, 1);
    test_random(100);
    set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(16 << FRAC_BITS));
    test_random(430);
    drain();

    $display("Sent %0d rays over six sphere settings, with idle, stall and", rays_sent);
    $display("long receiver hold-off phases; %0d results checked.", results_seen);
    if (error_count == 0) begin
      $display("ray_sphere_intersect: match");
    end else begin
      $display("ray_sphere_intersect: mismatch");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20000000;
    $display("ray_sphere_intersect: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

[ray_sphere_intersect.f]
sv/rsi_pkg.sv
sv/rsi_wmul.sv
sv/rsi_sqrt.sv
sv/rsi_div.sv
sv/rsi_obuf.sv
sv/ray_sphere_intersect.sv
sv/rsi_checker.sv
tb/ray_sphere_intersect_tb.sv
